// File: sv/sf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sf_pkg
// Shared sizes, register indexes, sequencer states and the LFO sine table of
// the stereo flanger.
// ----------------------------------------------------------------------------
package sf_pkg;

  localparam int DELAY_FRAMES = 4096;
  localparam int SAMPLE_BITS  = 16;
  localparam int SINE_POINTS  = 1024;

  localparam int ADDR_W     = $clog2(DELAY_FRAMES);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SINE_IDX_W = $clog2(SINE_POINTS);
  localparam int PHASE_W    = 16;
  localparam int COEF_W     = 16;
  localparam int DLEN_W     = 13;
  localparam int SWEEP_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEREO,
    REG_DELAY_LENGTH,
    REG_SWEEP_BASE,
    REG_SWEEP_DEPTH,
    REG_LFO_STEP,
    REG_MIX_RATIO,
    REG_FEEDBACK
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_OFS,
    ST_ADDR,
    ST_RDHI,
    ST_INTERP,
    ST_MIX,
    ST_WRITE
  } sf_state_t;

  typedef logic signed [COEF_W-1:0] sine_tab_t [SINE_POINTS];

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // quadrant fold, then a Q30 taylor series up to x^11
  function automatic logic signed [COEF_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] q;
    logic [1:0]  quad;
    u    = (64'(k) << 32) / 64'(SINE_POINTS);
    quad = u[31:30];
    f    = u & (Q30_ONE - 64'd1);
    t    = quad[0] ? (Q30_ONE - f) : f;
    x    = (t * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    r    = Q30_ONE;
    r    = Q30_ONE - ((x2 * r) >> 30) / 64'd110;
    r    = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
    r    = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
    r    = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
    r    = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
    s    = (x * r) >> 30;
    q    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return quad[1] ? -$signed(COEF_W'(q)) : $signed(COEF_W'(q));
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int k = 0; k < SINE_POINTS; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// File: sv/stereo_flanger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_flanger_top
// LFO-modulated fractional delay with feedback for mono or stereo frames.
// ----------------------------------------------------------------------------
// One frame is accepted, then a sequencer runs it through seven steps before
// the next frame is taken. The number of steps is set by the single read port
// of the delay memory (two taps, lo and hi, read in consecutive cycles) and
// by the chain of dependent multiplies (LFO swing, interpolation, mix and
// feedback), each followed by a register. A finished result waits in the
// output register while the next frame is already accepted; the write-back of
// a frame waits only if that register is still full. After reset the delay
// memory is cleared one frame per cycle, during which no frame is accepted;
// configuration writes are taken at any time (cfg_ready is always high) but
// should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module stereo_flanger_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sf_pkg::SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [sf_pkg::SAMPLE_BITS-1:0] in_right_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sf_pkg::SAMPLE_BITS-1:0] out_left_out,
  output logic signed [sf_pkg::SAMPLE_BITS-1:0] out_right_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sf_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import sf_pkg::*;

  localparam int SW     = SAMPLE_BITS;
  localparam int PROD_W = SWEEP_W + 1 + COEF_W;
  localparam int SWG_W  = PROD_W - 15;
  localparam int OFSR_W = SWEEP_W + 4;
  localparam int OFS_W  = LEN_W + 8;
  localparam int RP_W   = ADDR_W + 10;
  localparam int ISUM_W = SW + 11;
  localparam int WET_W  = SW + 18;
  localparam int FBP_W  = SW + COEF_W;
  localparam int FBS_W  = FBP_W - 15;
  localparam int SATI_W = WET_W - 15;

  localparam logic signed [SATI_W-1:0] SMP_HI = SATI_W'((1 << (SW - 1)) - 1);
  localparam logic signed [SATI_W-1:0] SMP_LO = SATI_W'(-(1 << (SW - 1)));
  localparam logic [COEF_W-1:0]        UNITY  = COEF_W'(32768);

  function automatic logic signed [SW-1:0] sat_smp(input logic signed [SATI_W-1:0] v);
    logic signed [SW-1:0] res;
    if (v > SMP_HI) begin
      res = SMP_HI[SW-1:0];
    end else if (v < SMP_LO) begin
      res = SMP_LO[SW-1:0];
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic                      stereo_r;
  logic [DLEN_W-1:0]         delay_length_r;
  logic [SWEEP_W-1:0]        sweep_base_r;
  logic [SWEEP_W-1:0]        sweep_depth_r;
  logic [PHASE_W-1:0]        lfo_step_r;
  logic [COEF_W-1:0]         mix_ratio_r;
  logic signed [COEF_W-1:0]  feedback_r;

  // control state
  sf_state_t                 state_r;
  sf_state_t                 state_nxt;
  logic [ADDR_W-1:0]         clr_cnt_r;
  logic [ADDR_W-1:0]         write_index_r;
  logic [PHASE_W-1:0]        lfo_phase_r;
  logic                      out_valid_r;
  logic signed [SW-1:0]      out_left_r;
  logic signed [SW-1:0]      out_right_r;

  // datapath registers
  logic signed [SW-1:0]      x_r [2];
  logic signed [COEF_W-1:0]  s_r;
  logic [LEN_W-1:0]          len_r;
  logic [ADDR_W-1:0]         w_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [OFS_W-1:0]          ofs_r;
  logic [ADDR_W-1:0]         hi_r;
  logic [7:0]                frac_r;
  logic [2*SW-1:0]           a_r;
  logic signed [SW-1:0]      d_r [2];
  logic signed [WET_W-1:0]   wet_r [2];
  logic signed [FBP_W-1:0]   fbp_r [2];

  // delay memory, right channel in the upper half
  logic [2*SW-1:0]           mem [DELAY_FRAMES];
  logic [2*SW-1:0]           rd_data_r;
  logic [ADDR_W-1:0]         mem_raddr;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [2*SW-1:0]           mem_wdata;
  logic                      mem_we_lo;
  logic                      mem_we_hi;

  logic                      out_load;

  // combinational datapath
  logic [LEN_W-1:0]          len_c;
  logic [ADDR_W-1:0]         w_c;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [SWG_W-1:0]   swing;
  logic signed [OFSR_W-1:0]  ofs_raw;
  logic [OFS_W-1:0]          maxoff;
  logic [OFS_W-1:0]          ofs_c;
  logic [RP_W-1:0]           rp_c;
  logic [RP_W-1:0]           rp_w;
  logic [ADDR_W-1:0]         lo_c;
  logic [LEN_W-1:0]          lo_inc;
  logic [ADDR_W-1:0]         hi_c;
  logic [COEF_W-1:0]         mix_c;
  logic [COEF_W-1:0]         dry_c;
  logic [8:0]                wlo_c;
  logic signed [ISUM_W-1:0]  isum_c [2];
  logic signed [SW-1:0]      y_c [2];
  logic signed [SW-1:0]      st_c [2];
  logic [LEN_W-1:0]          wi_inc;

  always_comb begin
    if (32'(delay_length_r) < 2) begin
      len_c = LEN_W'(2);
    end else if (32'(delay_length_r) > DELAY_FRAMES) begin
      len_c = LEN_W'(DELAY_FRAMES);
    end else begin
      len_c = LEN_W'(delay_length_r);
    end
    w_c = (LEN_W'(write_index_r) < len_c) ? write_index_r : '0;
  end

  // offset = base + round(depth * sin / 2^15), clamped to the line
  always_comb begin
    prod_rnd = prod_r + PROD_W'(1 << 14);
    swing    = prod_rnd[PROD_W-1:15];
    ofs_raw  = $signed(OFSR_W'(sweep_base_r)) + OFSR_W'(swing);
    maxoff   = {len_r - 1'b1, 8'hFF};
    if (ofs_raw[OFSR_W-1]) begin
      ofs_c = '0;
    end else if (ofs_raw[OFSR_W-2:0] > (OFSR_W-1)'(maxoff)) begin
      ofs_c = maxoff;
    end else begin
      ofs_c = ofs_raw[OFS_W-1:0];
    end
  end

  // read position behind the write index, wrapping at the line length
  always_comb begin
    rp_c = RP_W'({w_r, 8'h00}) - RP_W'(ofs_r);
    if (rp_c[RP_W-1]) begin
      rp_w = rp_c + RP_W'({len_r, 8'h00});
    end else begin
      rp_w = rp_c;
    end
    lo_c   = rp_w[ADDR_W+7:8];
    lo_inc = LEN_W'(lo_c) + 1'b1;
    hi_c   = (lo_inc >= len_r) ? '0 : lo_inc[ADDR_W-1:0];
  end

  always_comb begin
    mix_c = (mix_ratio_r > UNITY) ? UNITY : mix_ratio_r;
    dry_c = UNITY - mix_c;
    wlo_c = 9'd256 - {1'b0, frac_r};
    for (int c = 0; c < 2; c++) begin
      isum_c[c] = $signed(a_r[c*SW +: SW]) * $signed({1'b0, wlo_c})
                + $signed(rd_data_r[c*SW +: SW]) * $signed({1'b0, frac_r})
                + ISUM_W'(128);
    end
  end

  // rounding shift by 15 and saturation of output and write-back sample
  always_comb begin
    logic signed [WET_W-1:0] wet_rnd;
    logic signed [FBP_W-1:0] fb_rnd;
    logic signed [FBS_W-1:0] fbs;
    logic signed [SW+1:0]    st_sum;
    for (int c = 0; c < 2; c++) begin
      wet_rnd = wet_r[c] + WET_W'(1 << 14);
      y_c[c]  = sat_smp(wet_rnd[WET_W-1:15]);
      fb_rnd  = fbp_r[c] + FBP_W'(1 << 14);
      fbs     = fb_rnd[FBP_W-1:15];
      st_sum  = (SW+2)'(x_r[c]) + (SW+2)'(fbs);
      st_c[c] = sat_smp(SATI_W'(st_sum));
    end
  end

  assign wi_inc = LEN_W'(w_r) + 1'b1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    mem_we_lo = 1'b0;
    mem_we_hi = 1'b0;
    mem_waddr = w_r;
    mem_wdata = {st_c[1], st_c[0]};
    mem_raddr = hi_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we_lo = 1'b1;
        mem_we_hi = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == ADDR_W'(DELAY_FRAMES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:    state_nxt = ST_OFS;
      ST_OFS:    state_nxt = ST_ADDR;
      ST_ADDR: begin
        mem_raddr = lo_c;
        state_nxt = ST_RDHI;
      end
      ST_RDHI:   state_nxt = ST_INTERP;
      ST_INTERP: state_nxt = ST_MIX;
      ST_MIX:    state_nxt = ST_WRITE;
      ST_WRITE: begin
        // hold the write-back until the output register is free
        if (!out_valid_r || !out_stall) begin
          mem_we_lo = 1'b1;
          mem_we_hi = stereo_r;
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we_lo) begin
      mem[mem_waddr][SW-1:0] <= mem_wdata[SW-1:0];
    end
    if (mem_we_hi) begin
      mem[mem_waddr][2*SW-1:SW] <= mem_wdata[2*SW-1:SW];
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      write_index_r  <= '0;
      lfo_phase_r    <= '0;
      out_valid_r    <= 1'b0;
      stereo_r       <= 1'b0;
      delay_length_r <= DLEN_W'(4096);
      sweep_base_r   <= SWEEP_W'(512);
      sweep_depth_r  <= '0;
      lfo_step_r     <= '0;
      mix_ratio_r    <= COEF_W'(16384);
      feedback_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r   <= 1'b1;
        write_index_r <= (wi_inc >= len_r) ? '0 : wi_inc[ADDR_W-1:0];
        lfo_phase_r   <= lfo_phase_r + lfo_step_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STEREO:       stereo_r       <= cfg_data[0];
          REG_DELAY_LENGTH: delay_length_r <= cfg_data[DLEN_W-1:0];
          REG_SWEEP_BASE:   sweep_base_r   <= cfg_data[SWEEP_W-1:0];
          REG_SWEEP_DEPTH:  sweep_depth_r  <= cfg_data[SWEEP_W-1:0];
          REG_LFO_STEP:     lfo_step_r     <= cfg_data[PHASE_W-1:0];
          REG_MIX_RATIO:    mix_ratio_r    <= cfg_data[COEF_W-1:0];
          REG_FEEDBACK:     feedback_r     <= $signed(cfg_data[COEF_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= y_c[0];
      out_right_r <= stereo_r ? y_c[1] : '0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x_r[0] <= in_left_in;
          x_r[1] <= in_right_in;
          s_r    <= SINE_TAB[lfo_phase_r[PHASE_W-1 -: SINE_IDX_W]];
          len_r  <= len_c;
          w_r    <= w_c;
        end
      end
      ST_MUL:  prod_r <= $signed({1'b0, sweep_depth_r}) * s_r;
      ST_OFS:  ofs_r  <= ofs_c;
      ST_ADDR: begin
        hi_r   <= hi_c;
        frac_r <= rp_w[7:0];
      end
      ST_RDHI: a_r <= rd_data_r;
      ST_INTERP: begin
        for (int c = 0; c < 2; c++) begin
          d_r[c] <= isum_c[c][SW+7:8];
        end
      end
      ST_MIX: begin
        for (int c = 0; c < 2; c++) begin
          wet_r[c] <= x_r[c] * $signed({1'b0, dry_c}) + d_r[c] * $signed({1'b0, mix_c});
          fbp_r[c] <= d_r[c] * feedback_r;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule

// File: test/stereo_flanger_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_flanger_checker
// Watches the frame, result and register channels of the stereo flanger. It
// keeps its own delay line, LFO phase and register copy, predicts each output
// frame and compares the results in order.
// ----------------------------------------------------------------------------
module stereo_flanger_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [sf_pkg::SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [sf_pkg::SAMPLE_BITS-1:0] in_right_in,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [sf_pkg::SAMPLE_BITS-1:0] out_left_out,
  input  logic signed [sf_pkg::SAMPLE_BITS-1:0] out_right_out,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [sf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sf_pkg::CFG_DATA_W-1:0]         cfg_data,
  output int                                    fail_count,
  output int                                    outstanding
);
  import sf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  frame_t expected_frames[$];

  logic                 cfg_stereo;
  logic [DLEN_W-1:0]    cfg_dlen;
  logic [SWEEP_W-1:0]   cfg_base;
  logic [SWEEP_W-1:0]   cfg_depth;
  logic [PHASE_W-1:0]   cfg_step;
  logic [COEF_W-1:0]    cfg_mix;
  logic signed [COEF_W-1:0] cfg_fb;

  sample_t     delay_line [2][DELAY_FRAMES];
  int          wr_pos;
  logic [PHASE_W-1:0] lfo_acc;
  sample_t     sine_lut [SINE_POINTS];

  // q1.15 sine over a full circle: fold into the first quadrant, then an
  // x^11 taylor series in q30
  function automatic sample_t lfo_sine(input int unsigned k);
    logic [63:0] pos, frac, fold, x, x2, r, s, q;
    int unsigned taylor_div [5];
    taylor_div = '{110, 72, 42, 20, 6};
    pos  = (64'(k) << 32) / 64'(SINE_POINTS);
    frac = pos & 64'h3FFF_FFFF;
    fold = pos[30] ? (64'h4000_0000 - frac) : frac;
    x    = (fold * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    r    = 64'h4000_0000;
    foreach (taylor_div[i]) begin
      r = 64'h4000_0000 - ((x2 * r) >> 30) / 64'(taylor_div[i]);
    end
    s = (x * r) >> 30;
    q = (s * 64'd32767 + 64'h2000_0000) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return pos[31] ? -sample_t'(q[15:0]) : sample_t'(q[15:0]);
  endfunction

  // shift right, rounding half up
  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic sample_t clip16(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return sample_t'(v);
  endfunction

  initial begin
    for (int k = 0; k < SINE_POINTS; k++) begin
      sine_lut[k] = lfo_sine(k);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic flange_frame(input sample_t l, input sample_t r);
    int      len, w, lo, hi, nch;
    longint  ofs, rp, frac, mx, x, a, b, d;
    sample_t y;
    frame_t  res;
    len = cfg_dlen;
    if (len < 2) begin
      len = 2;
    end
    if (len > DELAY_FRAMES) begin
      len = DELAY_FRAMES;
    end
    // a shrunk line restarts at frame zero
    w = (wr_pos < len) ? wr_pos : 0;
    ofs = longint'(cfg_base) + round_shift(longint'(cfg_depth) *
          longint'(sine_lut[(32'(lfo_acc) * SINE_POINTS) >> 16]), 15);
    if (ofs < 0) begin
      ofs = 0;
    end
    if (ofs > longint'(len) * 256 - 1) begin
      ofs = longint'(len) * 256 - 1;
    end
    rp = longint'(w) * 256 - ofs;
    if (rp < 0) begin
      rp += longint'(len) * 256;
    end
    lo   = int'(rp >>> 8);
    frac = rp & 255;
    hi   = (lo + 1 >= len) ? 0 : lo + 1;
    mx   = (cfg_mix > 16'd32768) ? 64'sd32768 : longint'(cfg_mix);
    nch  = cfg_stereo ? 2 : 1;
    res  = '0;
    for (int c = 0; c < nch; c++) begin
      x = (c == 0) ? longint'(l) : longint'(r);
      a = delay_line[c][lo];
      b = delay_line[c][hi];
      d = round_shift(a * (256 - frac) + b * frac, 8);
      y = clip16(round_shift(x * (32768 - mx) + d * mx, 15));
      delay_line[c][w] = clip16(x + round_shift(d * longint'(cfg_fb), 15));
      if (c == 0) begin
        res.left = y;
      end else begin
        res.right = y;
      end
    end
    expected_frames.push_back(res);
    w++;
    wr_pos  = (w >= len) ? 0 : w;
    lfo_acc = lfo_acc + cfg_step;
  endtask

  task automatic check_frame(input sample_t l, input sample_t r);
    frame_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d with nothing pending", l, r));
    end else begin
      want = expected_frames.pop_front();
      if (l !== want.left) begin
        report_mismatch($sformatf("left_out %0d, expected %0d", l, want.left));
      end
      if (r !== want.right) begin
        report_mismatch($sformatf("right_out %0d, expected %0d", r, want.right));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_stereo = 1'b0;
      cfg_dlen   = DLEN_W'(DELAY_FRAMES);
      cfg_base   = SWEEP_W'(512);
      cfg_depth  = '0;
      cfg_step   = '0;
      cfg_mix    = COEF_W'(16384);
      cfg_fb     = '0;
      wr_pos     = 0;
      lfo_acc    = '0;
      for (int i = 0; i < DELAY_FRAMES; i++) begin
        delay_line[0][i] = '0;
        delay_line[1][i] = '0;
      end
      expected_frames.delete();
      fail_count  = 0;
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEREO:       cfg_stereo = cfg_data[0];
          REG_DELAY_LENGTH: cfg_dlen   = cfg_data[DLEN_W-1:0];
          REG_SWEEP_BASE:   cfg_base   = cfg_data[SWEEP_W-1:0];
          REG_SWEEP_DEPTH:  cfg_depth  = cfg_data[SWEEP_W-1:0];
          REG_LFO_STEP:     cfg_step   = cfg_data[PHASE_W-1:0];
          REG_MIX_RATIO:    cfg_mix    = cfg_data[COEF_W-1:0];
          REG_FEEDBACK:     cfg_fb     = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        check_frame(out_left_out, out_right_out);
      end
      if (in_valid && !in_stall) begin
        flange_frame(in_left_in, in_right_in);
      end
      outstanding = expected_frames.size();
    end
  end

endmodule

// File: test/tb_stereo_flanger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_flanger_top
// Drives the stereo flanger with a directed set of corner frames and register
// settings, then random phases of audio frames under random settings, with
// random gaps and stalls on both channels and a long output hold-off. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stereo_flanger_top;
  import sf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 900;

  typedef struct {
    logic                     stereo;
    logic [DLEN_W-1:0]        dlen;
    logic [SWEEP_W-1:0]       base;
    logic [SWEEP_W-1:0]       depth;
    logic [PHASE_W-1:0]       step;
    logic [COEF_W-1:0]        mix;
    logic signed [COEF_W-1:0] fb;
  } flanger_setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_BITS-1:0] in_left_in;
  logic signed [SAMPLE_BITS-1:0] in_right_in;
  logic out_valid;
  logic out_stall;
  logic signed [SAMPLE_BITS-1:0] out_left_out;
  logic signed [SAMPLE_BITS-1:0] out_right_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fails;
  int outstanding;
  int cycle_count = 0;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;

  stereo_flanger_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  stereo_flanger_checker flange_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fails),
    .outstanding   (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL stereo_flanger_top");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= rx_gaps && ($urandom_range(99) < 8);
    end
  end

  // every task below starts and ends at a falling edge
  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r);
    while (tx_gaps && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= l;
    in_right_in <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic program_setting(input flanger_setting_t s);
    write_reg(REG_STEREO,       CFG_DATA_W'(s.stereo));
    write_reg(REG_DELAY_LENGTH, CFG_DATA_W'(s.dlen));
    write_reg(REG_SWEEP_BASE,   s.base);
    write_reg(REG_SWEEP_DEPTH,  s.depth);
    write_reg(REG_LFO_STEP,     CFG_DATA_W'(s.step));
    write_reg(REG_MIX_RATIO,    CFG_DATA_W'(s.mix));
    write_reg(REG_FEEDBACK,     {4'b0, s.fb});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering frames and let every pending result and write-back finish
  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_BITS-1:0] corner [8];
    flanger_setting_t s;
    int sent, n, i, ph, span, t;

    corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, -16'sd1,
               16'sd1, 16'sh5555, 16'shAAAA, 16'sd16384};
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_left_in  = '0;
    in_right_in = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_STEREO;
    cfg_data    = '0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    hold_req    = 1'b0;
    sent        = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // power-up settings, mono: the right input is ignored
    for (i = 0; i < 8; i++) begin
      send_frame(corner[i], corner[7 - i]);
    end
    drain_block();

    // stereo, length below the minimum, zero offset, mix above one, full feedback
    program_setting('{1'b1, 13'd0, 20'd0, 20'd0, 16'd0, 16'hFFFF, 16'sh7FFF});
    for (i = 0; i < 5; i++) begin
      send_frame(16'sh7FFF, 16'sh8000);
    end
    drain_block();

    // length above the maximum, offset clamped at the top by the sweep
    program_setting('{1'b1, 13'h1FFF, 20'hFFFFF, 20'hFFFFF, 16'd16384, 16'd0,
                      -16'sd32767});
    for (i = 0; i < 5; i++) begin
      send_frame(corner[i], corner[i + 1]);
    end
    drain_block();

    // line shrunk below the write position
    program_setting('{1'b0, 13'd3, 20'd300, 20'd200, 16'd40000, 16'd32768,
                      16'sd12345});
    for (i = 0; i < 4; i++) begin
      send_frame(corner[i + 4], corner[i]);
    end
    drain_block();

    for (ph = 0; sent < ITEM_TARGET; ph++) begin
      s.stereo = 1'($urandom_range(1));
      case ($urandom_range(3))
        0:       s.dlen = DLEN_W'($urandom_range(64, 2));
        1:       s.dlen = DLEN_W'(DELAY_FRAMES);
        2:       s.dlen = DLEN_W'($urandom_range(DELAY_FRAMES, 2));
        default: s.dlen = $urandom_range(1) ? DLEN_W'($urandom_range(1))
                                            : DLEN_W'($urandom_range(8191, 4097));
      endcase
      span = (s.dlen < 2) ? 512 : (s.dlen > DELAY_FRAMES) ? DELAY_FRAMES * 256
                                                         : s.dlen * 256;
      s.base  = ($urandom_range(4) == 0) ? SWEEP_W'($urandom)
                                         : SWEEP_W'($urandom_range(span));
      s.depth = ($urandom_range(4) == 0) ? SWEEP_W'($urandom)
                                         : SWEEP_W'($urandom_range(s.base));
      s.step  = ($urandom_range(3) == 0) ? 16'($urandom_range(64)) : 16'($urandom);
      s.mix   = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
      t = $urandom_range(65534);
      s.fb = 16'(t - 32767);
      if (ph == 0) begin
        s = '{1'b0, 13'd2, 20'd0, 20'd0, 16'd0, 16'd0, -16'sd32767};
      end
      if (ph == 1) begin
        s = '{1'b1, 13'd4096, 20'd1048320, 20'd1048320, 16'hFFFF, 16'd32768,
              16'sd32767};
      end
      program_setting(s);

      // phase 2 backs up the block behind a held result, phase 3 runs flat out
      tx_gaps = (ph != 2 && ph != 3);
      rx_gaps = (ph != 3);
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      n = $urandom_range(100, 50);
      for (i = 0; i < n; i++) begin
        if (ph == 4 && i == n / 2) begin
          drain_block();
        end
        send_frame(pick_sample(), pick_sample());
        sent++;
      end
      drain_block();
    end

    repeat (20) @(negedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("PASS stereo_flanger_top");
    end else begin
      $display("FAIL stereo_flanger_top");
    end
    $finish;
  end

endmodule
